// File: hw/rtl/wqo_pkg.sv
`timescale 1ns / 1ps
package wqo_pkg;

  // Field widths of the stream and configuration payloads.
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 26;
  localparam int LEN_W    = 11;
  localparam int INDEX_W  = 10;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam int MIN_LEN = 4;

  // Command queue between the front and the back. Depth is a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIPOLAR_MODE = 2'd2;

  localparam logic [STEP_W-1:0] PHASE_STEP_RESET   = 26'd65536;
  localparam logic [LEN_W-1:0]  TABLE_LENGTH_RESET = 11'd1024;

  typedef enum logic {
    OP_TICK,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [INDEX_W-1:0]         table_index;
    logic signed [SAMPLE_W-1:0] table_value;
  } cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0] phase_step;
    logic [LEN_W-1:0]  table_length;
    logic              unipolar_mode;
  } cfg_t;

endpackage

// File: hw/rtl/wqo_front.sv
`timescale 1ns / 1ps
module wqo_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wqo_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tuser,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output wqo_pkg::cmd_t                      cmd
);
  import wqo_pkg::*;

  cmd_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  cmd_t              in_cmd;
  logic              push, pop, in_range;

  always_comb begin
    in_cmd.op          = in_tuser ? OP_WRITE : OP_TICK;
    in_cmd.table_index = in_tdata[INDEX_W-1:0];
    in_cmd.table_value = in_tdata[INDEX_W+SAMPLE_W-1:INDEX_W];
  end

  // Writes past the end of the table are consumed here and never queued.
  assign in_range  = int'(in_cmd.table_index) < TABLE_DEPTH;
  assign in_tready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign push      = in_tvalid && in_tready && ((in_cmd.op == OP_TICK) || in_range);
  assign cmd_valid = count_r != '0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// File: hw/rtl/wqo_back.sv
`timescale 1ns / 1ps
module wqo_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wqo_pkg::cfg_t                      cfg,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  wqo_pkg::cmd_t                      cmd,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wqo_pkg::SAMPLE_W-1:0] out_sample,
  output logic signed [wqo_pkg::SAMPLE_W-1:0] out_quad
);
  import wqo_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int LW  = $clog2(TABLE_DEPTH + 1);
  localparam int IW  = AW + 2;
  localparam int PW  = AW + FRAC_W;
  localparam int LMW = PW + 1;
  localparam int CW  = (LMW > STEP_W) ? LMW : STEP_W;
  localparam int DW  = SAMPLE_W + 1;
  localparam int AC  = SAMPLE_W + FRAC_W + 2;
  localparam logic signed [AC-1:0] ROUND =
    {{(AC-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

  // Settings derived from the configuration registers, refreshed every cycle.
  logic [LW-1:0]  len_c, len_r;
  logic [LMW-1:0] limit_c, limit_r;
  logic [PW-1:0]  step_c, step_r;
  logic [AW-1:0]  quarter_r;
  logic           uni_r;

  always_comb begin
    if (cfg.table_length < LEN_W'(MIN_LEN)) begin
      len_c = LW'(MIN_LEN);
    end else if (int'(cfg.table_length) > TABLE_DEPTH) begin
      len_c = LW'(TABLE_DEPTH);
    end else begin
      len_c = LW'(cfg.table_length);
    end
    limit_c = LMW'(len_c) << FRAC_W;
    if (CW'(cfg.phase_step) >= CW'(limit_c)) begin
      step_c = PW'(limit_c - 1'b1);
    end else begin
      step_c = PW'(cfg.phase_step);
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_c;
    limit_r   <= limit_c;
    step_r    <= step_c;
    quarter_r <= AW'(len_c >> 2);
    uni_r     <= cfg.unipolar_mode;
  end

  // Issue stage: phase, table addresses and table write.
  logic [PW-1:0]     phase_r, phase_nxt, ph;
  logic [AW-1:0]     idx, nxt, qidx, qnxt;
  logic [FRAC_W-1:0] frac;
  logic [IW-1:0]     len_x, i1, q0, q1;
  logic [LMW-1:0]    sum, wrapped;
  logic              adv, pop, tick, wr_en;

  assign adv       = !out_valid || out_ready;
  assign cmd_ready = adv;
  assign pop       = cmd_valid && adv;
  assign tick      = pop && (cmd.op == OP_TICK);
  assign wr_en     = pop && (cmd.op == OP_WRITE);

  always_comb begin
    // A phase left past the end by a shorter length restarts at zero.
    ph    = (LMW'(phase_r) >= limit_r) ? '0 : phase_r;
    idx   = ph[PW-1:FRAC_W];
    frac  = ph[FRAC_W-1:0];
    len_x = IW'(len_r);
    i1    = IW'(idx) + 1'b1;
    q0    = IW'(idx) + IW'(quarter_r);
    q1    = q0 + 1'b1;
    nxt   = (i1 >= len_x) ? AW'(i1 - len_x) : AW'(i1);
    qidx  = (q0 >= len_x) ? AW'(q0 - len_x) : AW'(q0);
    qnxt  = (q1 >= len_x) ? AW'(q1 - len_x) : AW'(q1);
    sum       = LMW'(ph) + LMW'(step_r);
    wrapped   = sum - limit_r;
    phase_nxt = (sum >= limit_r) ? PW'(wrapped) : PW'(sum);
  end

  // Two copies of the table so that each copy needs only two read ports.
  logic signed [SAMPLE_W-1:0] tbl_i_r [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] tbl_q_r [TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] a1_r, b1_r, qa1_r, qb1_r;
  logic [FRAC_W-1:0]          f1_r;
  logic                       v1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_i_r[AW'(cmd.table_index)] <= cmd.table_value;
      tbl_q_r[AW'(cmd.table_index)] <= cmd.table_value;
    end
    if (tick) begin
      a1_r  <= tbl_i_r[idx];
      b1_r  <= tbl_i_r[nxt];
      qa1_r <= tbl_q_r[qidx];
      qb1_r <= tbl_q_r[qnxt];
      f1_r  <= frac;
    end
  end

  // Multiply stage: slope times fraction.
  logic signed [DW-1:0]   d_i, d_q;
  logic signed [DW-1:0]   f_s;
  logic signed [2*DW-1:0] prod_i_r, prod_q_r;
  logic signed [SAMPLE_W-1:0] a2_r, qa2_r;
  logic                   v2_r;

  assign d_i = $signed({b1_r[SAMPLE_W-1], b1_r}) - $signed({a1_r[SAMPLE_W-1], a1_r});
  assign d_q = $signed({qb1_r[SAMPLE_W-1], qb1_r}) - $signed({qa1_r[SAMPLE_W-1], qa1_r});
  assign f_s = $signed({1'b0, f1_r});

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      prod_i_r <= d_i * f_s;
      prod_q_r <= d_q * f_s;
      a2_r     <= a1_r;
      qa2_r    <= qa1_r;
    end
  end

  // Round, scale and map to the output range.
  logic signed [AC-1:0]       acc_i, acc_q;
  logic signed [SAMPLE_W-1:0] y_i, y_q, s_i, s_q;
  logic signed [SAMPLE_W-1:0] sample_r, quad_r;
  logic                       out_valid_r;

  always_comb begin
    acc_i = (AC'(a2_r) <<< FRAC_W) + AC'(prod_i_r) + ROUND;
    acc_q = (AC'(qa2_r) <<< FRAC_W) + AC'(prod_q_r) + ROUND;
    y_i   = acc_i[FRAC_W+SAMPLE_W-1:FRAC_W];
    y_q   = acc_q[FRAC_W+SAMPLE_W-1:FRAC_W];
    // Flipping the sign bit gives the offset-binary value; halving it is unipolar.
    s_i = uni_r ? {1'b0, ~y_i[SAMPLE_W-1], y_i[SAMPLE_W-2:1]} : y_i;
    s_q = uni_r ? {1'b0, ~y_q[SAMPLE_W-1], y_q[SAMPLE_W-2:1]} : y_q;
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      sample_r <= s_i;
      quad_r   <= s_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick) begin
        phase_r <= phase_nxt;
      end
      if (adv) begin
        v1_r        <= tick;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_quad   = quad_r;

endmodule

// File: hw/rtl/wavetable_quadrature_oscillator_core.sv
`timescale 1ns / 1ps
// A tick passes the command queue and the issue, multiply and output registers in that order.
// Throughput: one transaction per cycle unless the output stalls; two read ports per table copy.
// Table writes produce no result and take one issue slot each.
// Reset: configuration takes its reset values, phase is zero, queue and pipeline are empty.
// The wave table is not cleared and holds whatever it held until written.
module wavetable_quadrature_oscillator_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] table_index, [25:10] table_value, [31:26] zero
  input  logic [wqo_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] command
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] sample, [31:16] quad_sample
  output logic [wqo_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wqo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wqo_pkg::STEP_W-1:0]          cfg_data
);
  import wqo_pkg::*;

  logic [STEP_W-1:0] phase_step_r;
  logic [LEN_W-1:0]  table_length_r;
  logic              unipolar_mode_r;
  cfg_t              cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= PHASE_STEP_RESET;
      table_length_r  <= TABLE_LENGTH_RESET;
      unipolar_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP:    phase_step_r    <= cfg_data;
        REG_TABLE_LENGTH:  table_length_r  <= cfg_data[LEN_W-1:0];
        REG_UNIPOLAR_MODE: unipolar_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.phase_step    = phase_step_r;
    cfg.table_length  = table_length_r;
    cfg.unipolar_mode = unipolar_mode_r;
  end

  logic                       cmd_valid, cmd_ready;
  cmd_t                       cmd;
  logic signed [SAMPLE_W-1:0] sample, quad;

  wqo_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  wqo_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (sample),
    .out_quad   (quad)
  );

  assign out_tdata = {quad, sample};

endmodule

// File: hw/rtl/wqo_checker.sv
`timescale 1ns / 1ps
module wqo_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [wqo_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wqo_pkg::*;

  // A result offered and not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // The command queue can only fill up through an accepted transaction.
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("input stalled without a transaction");

endmodule

bind wavetable_quadrature_oscillator_core wqo_checker u_wqo_checker (.*);

// File: tb/sv/tb_wavetable_quadrature_oscillator_core.sv
`timescale 1ns / 1ps
module tb_wavetable_quadrature_oscillator_core;
  import wqo_pkg::*;

  localparam int TABLE_DEPTH    = 1024;
  localparam int LOADED_ENTRIES = 128;
  localparam int QUARTER_SPAN   = 8;
  localparam int PHASE_ITEMS    = 36;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PRINT_LIMIT    = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [STEP_W-1:0]    STEP_MAX   = {STEP_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] quad_sample;
    logic [SAMPLE_W-1:0] sample;
  } sample_pair_t;

  class oscillator_scoreboard;
    logic [STEP_W-1:0]          phase_step;
    logic [LEN_W-1:0]           table_length;
    logic                       unipolar_mode;
    longint unsigned            phase;
    logic signed [SAMPLE_W-1:0] wave_table [TABLE_DEPTH];
    sample_pair_t               expected_samples [$];
    int unsigned                error_count;

    function new();
      phase_step    = PHASE_STEP_RESET;
      table_length  = TABLE_LENGTH_RESET;
      unipolar_mode = 1'b0;
      phase         = 0;
      error_count   = 0;
      foreach (wave_table[i]) wave_table[i] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
      case (idx)
        REG_PHASE_STEP:    phase_step    = data;
        REG_TABLE_LENGTH:  table_length  = data[LEN_W-1:0];
        REG_UNIPOLAR_MODE: unipolar_mode = data[0];
        default: ;
      endcase
    endfunction

    // Round half up between a and b, then map to the selected output range.
    function logic [SAMPLE_W-1:0] interpolate(logic signed [SAMPLE_W-1:0] a,
                                              logic signed [SAMPLE_W-1:0] b,
                                              logic [FRAC_W-1:0] f);
      longint acc;
      longint y;
      acc = longint'(a) * (longint'(1) << FRAC_W) + (longint'(b) - longint'(a)) * longint'(f)
            + (longint'(1) << (FRAC_W - 1));
      y = acc >>> FRAC_W;
      if (unipolar_mode) return SAMPLE_W'((y + (longint'(1) << (SAMPLE_W - 1))) >> 1);
      else return SAMPLE_W'(y);
    endfunction

    function void note_transaction(op_t op, logic [INDEX_W-1:0] idx,
                                   logic [SAMPLE_W-1:0] val);
      longint unsigned len;
      longint unsigned limit;
      longint unsigned step;
      longint unsigned pos;
      longint unsigned nxt;
      longint unsigned qpos;
      longint unsigned qnxt;
      logic [FRAC_W-1:0] f;
      sample_pair_t pair;
      if (op == OP_WRITE) begin
        wave_table[idx] = val;
        return;
      end
      len = 64'(table_length);
      if (len < 64'(MIN_LEN)) len = 64'(MIN_LEN);
      if (len > 64'(TABLE_DEPTH)) len = 64'(TABLE_DEPTH);
      limit = len << FRAC_W;
      // The length may have been lowered below the current phase.
      if (phase >= limit) phase = 0;
      pos = phase >> FRAC_W;
      f = phase[FRAC_W-1:0];
      nxt = pos + 1;
      if (nxt >= len) nxt -= len;
      qpos = pos + (len >> 2);
      if (qpos >= len) qpos -= len;
      qnxt = qpos + 1;
      if (qnxt >= len) qnxt -= len;
      pair.sample      = interpolate(wave_table[pos], wave_table[nxt], f);
      pair.quad_sample = interpolate(wave_table[qpos], wave_table[qnxt], f);
      expected_samples.push_back(pair);
      step = 64'(phase_step);
      if (step >= limit) step = limit - 1;
      phase += step;
      if (phase >= limit) phase -= limit;
    endfunction

    task report_mismatch(string msg);
      if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
    endtask

    task check_sample(logic [OUT_DATA_W-1:0] data);
      sample_pair_t got;
      sample_pair_t exp_pair;
      got = data;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", data));
        return;
      end
      exp_pair = expected_samples.pop_front();
      if (got.sample !== exp_pair.sample)
        report_mismatch($sformatf("sample %h, expected %h", got.sample, exp_pair.sample));
      if (got.quad_sample !== exp_pair.quad_sample)
        report_mismatch($sformatf("quad_sample %h, expected %h",
                                  got.quad_sample, exp_pair.quad_sample));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [STEP_W-1:0]     cfg_data   = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  oscillator_scoreboard sb;

  wavetable_quadrature_oscillator_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(op_t op, logic [INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - INDEX_W - SAMPLE_W){1'b0}}, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_transaction(op, idx, val);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(OP_TICK, INDEX_W'($urandom), SAMPLE_W'($urandom));
  endtask

  // Writes produce no result, so an extra wait after the last expected result lets queued ones retire.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic apply_settings(logic [STEP_W-1:0] step, logic [LEN_W-1:0] len,
                                logic uni, bit hit_unused);
    wait_until_drained();
    write_register(REG_PHASE_STEP, step);
    write_register(REG_TABLE_LENGTH, STEP_W'(len));
    write_register(REG_UNIPOLAR_MODE, STEP_W'(uni));
    if (hit_unused) write_register(REG_UNUSED, STEP_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  initial begin
    logic [STEP_W-1:0] step;
    logic [LEN_W-1:0]  len;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks only ever reach the low entries and, while the full length is active,
    // the few entries a quarter table in, so only those are loaded.
    for (int i = 0; i < LOADED_ENTRIES; i++)
      send_item(OP_WRITE, INDEX_W'(i), SAMPLE_W'($urandom));
    for (int i = 0; i < QUARTER_SPAN; i++)
      send_item(OP_WRITE, INDEX_W'(TABLE_DEPTH / 4 + i), SAMPLE_W'($urandom));

    send_item(OP_WRITE, 10'd0, 16'h7FFF);
    send_item(OP_WRITE, 10'd1, 16'h8000);
    send_item(OP_WRITE, 10'd1023, 16'h8000);
    send_item(OP_WRITE, 10'd256, 16'h8000);
    send_item(OP_WRITE, 10'd257, 16'h7FFF);
    send_ticks(3);

    set_idling(3);
    apply_settings(26'h0008000, 11'd1024, 1'b0, 1'b0);
    send_ticks(3);
    // A step one fraction short of a full turn makes the phase creep backwards.
    apply_settings(STEP_MAX, 11'd1024, 1'b1, 1'b0);
    send_ticks(3);
    // Shrinking the table leaves the phase out of range for the next tick.
    apply_settings(26'h0028000, 11'd0, 1'b1, 1'b0);
    send_ticks(3);
    apply_settings(26'd0, 11'd2047, 1'b0, 1'b1);
    send_ticks(2);
    apply_settings(26'h007FFFF, 11'd5, 1'b0, 1'b0);
    send_ticks(3);

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(3))
        0: step = STEP_W'($urandom_range(0, 32'h40000));
        1: step = STEP_W'($urandom);
        2: step = STEP_MAX;
        default: step = STEP_W'($urandom_range(0, 32'h10000));
      endcase
      case ($urandom_range(3))
        0: len = LEN_W'($urandom_range(4, LOADED_ENTRIES));
        1: len = LEN_W'($urandom_range(4, 16));
        2: len = LEN_W'($urandom_range(0, 3));
        default: len = LEN_W'(LOADED_ENTRIES);
      endcase
      set_idling(p % 4);
      apply_settings(step, len, 1'($urandom_range(1)), 1'b0);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < 65) send_item(OP_TICK, INDEX_W'($urandom), SAMPLE_W'($urandom));
        else send_item(OP_WRITE, INDEX_W'($urandom), SAMPLE_W'($urandom));
      end
    end

    wait_until_drained();
    if (sb.error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
